// File: hdl/pss_pkg.sv
// Shared codes, widths and control structures of the platen stepper sequencer.
package pss_pkg;

	// Sequencer phase codes.
	localparam logic [2:0] PH_BOOT      = 3'd0;
	localparam logic [2:0] PH_BACK      = 3'd1;
	localparam logic [2:0] PH_STEPOFF   = 3'd2;
	localparam logic [2:0] PH_IDLEBACK  = 3'd3;
	localparam logic [2:0] PH_PRINT     = 3'd4;
	localparam logic [2:0] PH_FRONT     = 3'd5;
	localparam logic [2:0] PH_IDLEFRONT = 3'd6;

	// Step command codes.
	localparam logic [1:0] STEP_NONE = 2'd0;
	localparam logic [1:0] STEP_FWD  = 2'd1;
	localparam logic [1:0] STEP_REV  = 2'd2;

	// User command codes.
	localparam logic [2:0] CMD_NONE      = 3'd0;
	localparam logic [2:0] CMD_ONE_PASS  = 3'd1;
	localparam logic [2:0] CMD_TWO_PASS  = 3'd2;
	localparam logic [2:0] CMD_FRONT     = 3'd3;
	localparam logic [2:0] CMD_BACK_ONE  = 3'd4;
	localparam logic [2:0] CMD_BACK_TWO  = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] CFG_ALIGN_STEP = 3'd0;
	localparam logic [2:0] CFG_BOOT_STEP  = 3'd1;
	localparam logic [2:0] CFG_HOME_STEP  = 3'd2;
	localparam logic [2:0] CFG_EJECT_STEP = 3'd3;
	localparam logic [2:0] CFG_FRONT_LIM  = 3'd4;
	localparam logic [2:0] CFG_ENC_PER    = 3'd5;

	// Stream widths.
	localparam int IN_W  = 56;
	localparam int OUT_W = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       div_run;
		logic       commit;
		logic [1:0] step;
		logic       timer_restart;
		logic       pos_clear;
		logic       target_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       stop;
		logic       held;
		logic [2:0] cmd;
		logic       moved;
		logic       enc_gt1;
		logic       edge_hit;
		logic       el_align;
		logic       el_boot;
		logic       el_home;
		logic       el_eject;
		logic       pos_gt_limit;
		logic       tgt_gt_pos;
		logic       tgt_lt_pos;
		logic       div_last;
	} dp_status_t;

	// Result fields owned by the controller.
	typedef struct packed {
		logic [2:0] phase;
		logic       auto_ready;
		logic       encoder_enabled;
		logic       encoder_clear;
		logic       paper_release;
		logic       motor_off;
	} ctl_result_t;

endpackage

// File: hdl/pss_datapath.sv
// Datapath: item and configuration registers, step position, timer and serial divider.
module pss_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          now_ms,
	input  logic                 stop_pressed,
	input  logic                 plate_held,
	input  logic [2:0]           command,
	input  logic                 encoder_moved,
	input  logic signed [15:0]   encoder_count,
	input  logic                 at_platen_edge,
	input  logic                 cfg_wr,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  pss_pkg::dp_cmd_t     cmd,
	output pss_pkg::dp_status_t  status,
	output logic [15:0]          pos_next
);

	// One restoring division step: returns {remainder, shifted work word}.
	function automatic logic [23:0] div_step(input logic [7:0] rem, input logic [15:0] work,
		input logic [7:0] dsr);
		logic [8:0]  r9;
		logic [15:0] w;
		begin
			r9 = {rem, work[15]};
			w  = {work[14:0], 1'b0};
			if (r9 >= {1'b0, dsr}) begin
				r9   = r9 - {1'b0, dsr};
				w[0] = 1'b1;
			end
			div_step = {r9[7:0], w};
		end
	endfunction

	logic [15:0]        align_q, boot_q, home_q, eject_q;
	logic [14:0]        limit_q;
	logic [7:0]         enc_per_q;
	logic [31:0]        now_q, elapsed_q, timer_q;
	logic               stop_q, held_q, moved_q, edge_q;
	logic [2:0]         cmd_q;
	logic signed [15:0] enc_q;
	logic [15:0]        pos_q, tgt_q;
	logic               div_neg_q;
	logic [7:0]         div_rem_q;
	logic [15:0]        div_work_q;
	logic [2:0]         div_cnt_q;
	logic [7:0]         divisor;
	logic [23:0]        div_a, div_b;
	logic [15:0]        enc_mag, quot, tgt_eff, pos_base;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q   <= 16'd10;
			boot_q    <= 16'd2;
			home_q    <= 16'd2;
			eject_q   <= 16'd2;
			limit_q   <= 15'd8000;
			enc_per_q <= 8'd1;
		end else if (cfg_wr) begin
			case (cfg_index)
				pss_pkg::CFG_ALIGN_STEP: align_q   <= cfg_data;
				pss_pkg::CFG_BOOT_STEP:  boot_q    <= cfg_data;
				pss_pkg::CFG_HOME_STEP:  home_q    <= cfg_data;
				pss_pkg::CFG_EJECT_STEP: eject_q   <= cfg_data;
				pss_pkg::CFG_FRONT_LIM:  limit_q   <= cfg_data[14:0];
				pss_pkg::CFG_ENC_PER:    enc_per_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Item capture; elapsed time is taken against the timer as it stands now.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q     <= now_ms;
			elapsed_q <= now_ms - timer_q;
			stop_q    <= stop_pressed;
			held_q    <= plate_held;
			cmd_q     <= command;
			moved_q   <= encoder_moved;
			enc_q     <= encoder_count;
			edge_q    <= at_platen_edge;
		end
	end

	// Serial divider, two quotient bits per cycle on the encoder magnitude.
	assign divisor = (enc_per_q == 8'd0) ? 8'd1 : enc_per_q;
	assign enc_mag = encoder_count[15] ? (16'd0 - encoder_count) : encoder_count;
	assign div_a   = div_step(div_rem_q, div_work_q, divisor);
	assign div_b   = div_step(div_a[23:16], div_a[15:0], divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load) begin
			div_cnt_q <= '0;
		end else if (cmd.div_run) begin
			div_cnt_q <= div_cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_neg_q  <= encoder_count[15];
			div_rem_q  <= '0;
			div_work_q <= enc_mag;
		end else if (cmd.div_run) begin
			div_rem_q  <= div_b[23:16];
			div_work_q <= div_b[15:0];
		end
	end

	// Signed quotient, truncated toward zero, and the target in force this pass.
	assign quot    = div_neg_q ? (16'd0 - div_work_q) : div_work_q;
	assign tgt_eff = moved_q ? quot : tgt_q;

	// Next step position.
	always_comb begin
		pos_base = cmd.pos_clear ? 16'd0 : pos_q;
		case (cmd.step)
			pss_pkg::STEP_FWD: pos_next = pos_base + 16'd1;
			pss_pkg::STEP_REV: pos_next = pos_base - 16'd1;
			default:           pos_next = pos_base;
		endcase
	end

	// Sequencer state held in the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tgt_q   <= '0;
			timer_q <= '0;
		end else if (cmd.commit) begin
			pos_q <= pos_next;
			if (cmd.target_load) begin
				tgt_q <= quot;
			end
			if (cmd.timer_restart) begin
				timer_q <= now_q;
			end
		end
	end

	// Status toward the controller.
	always_comb begin
		status.stop         = stop_q;
		status.held         = held_q;
		status.cmd          = cmd_q;
		status.moved        = moved_q;
		status.enc_gt1      = enc_q > 16'sd1;
		status.edge_hit     = edge_q;
		status.el_align     = elapsed_q > {16'd0, align_q};
		status.el_boot      = elapsed_q > {16'd0, boot_q};
		status.el_home      = elapsed_q > {16'd0, home_q};
		status.el_eject     = elapsed_q > {16'd0, eject_q};
		status.pos_gt_limit = !pos_q[15] && (pos_q[14:0] > limit_q);
		status.tgt_gt_pos   = $signed(tgt_eff) > $signed(pos_q);
		status.tgt_lt_pos   = $signed(tgt_eff) < $signed(pos_q);
		status.div_last     = div_cnt_q == 3'd7;
	end

endmodule

// File: hdl/pss_ctrl.sv
// Controller: item sequencing and the seven-phase platen state machine.
module pss_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_free,
	input  pss_pkg::dp_status_t  status,
	output pss_pkg::dp_cmd_t     cmd,
	output pss_pkg::ctl_result_t res
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DIV    = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] seq_q, seq_d;
	logic [2:0] phase_q, phase_d;
	logic       sw_q, sw_d, tp_q, tp_d, auto_q, auto_d, encon_q, encon_d;
	logic       clr, paper, moff, commit;
	logic [1:0] step;
	logic       restart, pclear, tload;

	// Item sequencing: capture, divide, commit.
	assign in_ready = seq_q == S_IDLE;
	assign commit   = (seq_q == S_COMMIT) && out_free;

	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			S_IDLE:   if (in_valid) seq_d = S_DIV;
			S_DIV:    if (status.div_last) seq_d = S_COMMIT;
			S_COMMIT: if (out_free) seq_d = S_IDLE;
			default:  seq_d = S_IDLE;
		endcase
	end

	// Phase machine: next phase, flags, step and pulses for the held item.
	always_comb begin
		phase_d = phase_q;
		sw_d    = sw_q;
		tp_d    = tp_q;
		auto_d  = auto_q;
		encon_d = encon_q;
		step    = pss_pkg::STEP_NONE;
		restart = 1'b0;
		pclear  = 1'b0;
		tload   = 1'b0;
		clr     = 1'b0;
		paper   = 1'b0;
		moff    = 1'b0;
		case (phase_q)
			pss_pkg::PH_BACK: begin
				auto_d = 1'b1;
				if (status.cmd == pss_pkg::CMD_ONE_PASS) tp_d = 1'b0;
				else if (status.cmd == pss_pkg::CMD_TWO_PASS) tp_d = 1'b1;
				if (status.cmd == pss_pkg::CMD_FRONT) begin
					phase_d = pss_pkg::PH_FRONT;
				end else if (!status.held) begin
					if (status.stop) begin
						phase_d = pss_pkg::PH_STEPOFF;
					end else if (status.el_home) begin
						step    = pss_pkg::STEP_REV;
						restart = 1'b1;
					end
				end
			end
			pss_pkg::PH_STEPOFF: begin
				if (status.stop) begin
					if (status.el_align) begin
						step    = pss_pkg::STEP_FWD;
						restart = 1'b1;
					end
				end else begin
					clr     = 1'b1;
					pclear  = 1'b1;
					encon_d = 1'b1;
					auto_d  = 1'b0;
					phase_d = pss_pkg::PH_IDLEBACK;
				end
			end
			pss_pkg::PH_IDLEBACK: begin
				if (status.cmd == pss_pkg::CMD_ONE_PASS) tp_d = 1'b0;
				else if (status.cmd == pss_pkg::CMD_TWO_PASS) tp_d = 1'b1;
				if (status.cmd == pss_pkg::CMD_FRONT) begin
					encon_d = 1'b0;
					phase_d = pss_pkg::PH_FRONT;
				end else if (status.moved && status.enc_gt1) begin
					phase_d = pss_pkg::PH_PRINT;
				end
			end
			pss_pkg::PH_PRINT: begin
				auto_d = 1'b0;
				tload  = status.moved;
				if (status.tgt_gt_pos) step = pss_pkg::STEP_FWD;
				else if (status.tgt_lt_pos) step = pss_pkg::STEP_REV;
				if (status.edge_hit) begin
					paper   = 1'b1;
					encon_d = 1'b0;
					if (tp_q) begin
						tp_d    = 1'b0;
						phase_d = pss_pkg::PH_BACK;
					end else begin
						phase_d = pss_pkg::PH_FRONT;
					end
				end
			end
			pss_pkg::PH_FRONT: begin
				auto_d = 1'b0;
				if (status.cmd == pss_pkg::CMD_BACK_ONE) begin
					phase_d = pss_pkg::PH_BACK;
				end else if (status.cmd == pss_pkg::CMD_BACK_TWO) begin
					tp_d    = 1'b1;
					phase_d = pss_pkg::PH_BACK;
				end else if (status.pos_gt_limit) begin
					moff    = 1'b1;
					phase_d = pss_pkg::PH_IDLEFRONT;
				end else if (status.el_eject) begin
					step    = pss_pkg::STEP_FWD;
					restart = 1'b1;
				end
			end
			pss_pkg::PH_IDLEFRONT: begin
				if (status.cmd == pss_pkg::CMD_BACK_ONE) begin
					phase_d = pss_pkg::PH_BACK;
				end else if (status.cmd == pss_pkg::CMD_BACK_TWO) begin
					tp_d    = 1'b1;
					phase_d = pss_pkg::PH_BACK;
				end else begin
					auto_d = 1'b1;
				end
			end
			default: begin
				// Bootup homing; the unused phase code lands here as well.
				phase_d = pss_pkg::PH_BOOT;
				if (status.stop) begin
					sw_d = 1'b1;
					if (status.el_align) begin
						step    = pss_pkg::STEP_FWD;
						restart = 1'b1;
					end
				end else if (sw_q) begin
					sw_d    = 1'b0;
					pclear  = 1'b1;
					phase_d = pss_pkg::PH_FRONT;
				end else if (status.el_boot) begin
					step    = pss_pkg::STEP_REV;
					restart = 1'b1;
				end
			end
		endcase
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= S_IDLE;
			phase_q <= pss_pkg::PH_BOOT;
			sw_q    <= 1'b0;
			tp_q    <= 1'b0;
			auto_q  <= 1'b0;
			encon_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			if (commit) begin
				phase_q <= phase_d;
				sw_q    <= sw_d;
				tp_q    <= tp_d;
				auto_q  <= auto_d;
				encon_q <= encon_d;
			end
		end
	end

	// Datapath commands.
	always_comb begin
		cmd.load          = in_ready && in_valid;
		cmd.div_run       = seq_q == S_DIV;
		cmd.commit        = commit;
		cmd.step          = step;
		cmd.timer_restart = restart;
		cmd.pos_clear     = pclear;
		cmd.target_load   = tload;
	end

	// Result fields for the output register.
	always_comb begin
		res.phase           = phase_d;
		res.auto_ready      = auto_d;
		res.encoder_enabled = encon_d;
		res.encoder_clear   = clr;
		res.paper_release   = paper;
		res.motor_off       = moff;
	end

endmodule

// File: hdl/platen_stepper_sequencer_core.sv
// Platen stepper sequencer top level: stream ports, output register and checks.
// Each item passes through capture, the serial divider (two quotient bits per cycle)
// and commit to the output register; a new item is not taken until the last one
// is committed.
// A waiting result does not stall capture; commit waits for a free output register.
// Reset (arst_n low, asynchronous): bootup phase, all flags, position, target,
// timer cleared, configuration registers back to their defaults.
module platen_stepper_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] now_ms, [32] stop_pressed, [33] plate_held, [36:34] command,
	// [37] encoder_moved, [53:38] encoder_count, [54] at_platen_edge, [55] zero
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] phase, [4:3] step_cmd, [20:5] step_position, [21] auto_ready,
	// [22] encoder_enabled, [23] encoder_clear, [24] paper_release,
	// [25] motor_off, [31:26] zero
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	pss_pkg::dp_cmd_t     cmd;
	pss_pkg::dp_status_t  status;
	pss_pkg::ctl_result_t res;
	logic [15:0]          pos_next;
	logic                 out_free;
	logic                 m_tvalid_q;
	logic [31:0]          m_tdata_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	pss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd),
		.res      (res)
	);

	pss_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.now_ms         (s_tdata[31:0]),
		.stop_pressed   (s_tdata[32]),
		.plate_held     (s_tdata[33]),
		.command        (s_tdata[36:34]),
		.encoder_moved  (s_tdata[37]),
		.encoder_count  (s_tdata[53:38]),
		.at_platen_edge (s_tdata[54]),
		.cfg_wr         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.status         (status),
		.pos_next       (pos_next)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata_q <= {6'd0, res.motor_off, res.paper_release, res.encoder_clear,
				res.encoder_enabled, res.auto_ready, pos_next, cmd.step, res.phase};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// An accepted item closes the input until its result is committed.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// A commit never overwrites a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten");

	// A position clear never comes with a step in the same pass.
	a_clear_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && cmd.pos_clear |-> cmd.step == pss_pkg::STEP_NONE)
		else $error("step issued together with a position clear");

	// Commit only follows the last divider cycle or a stalled commit.
	a_commit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $past(status.div_last && cmd.div_run) || $past(!out_free))
		else $error("commit without a finished division");

endmodule
